### rtl/core/gffp_pkg.sv
// Package: shared constants, types and codes for the grid flood-fill painter.
`timescale 1ns / 1ps
package gffp_pkg;
    localparam int unsigned MaxWidth  = 256;
    localparam int unsigned MaxHeight = 256;
    localparam int unsigned ColorBits = 8;
    localparam int unsigned XBits     = $clog2(MaxWidth);
    localparam int unsigned YBits     = $clog2(MaxHeight);
    localparam int unsigned AddrBits  = XBits + YBits;
    localparam int unsigned CellCount = MaxWidth * MaxHeight;
    localparam int unsigned CntBits   = AddrBits + 1;

    localparam logic [1:0] ReqDraw  = 2'd0;
    localparam logic [1:0] ReqErase = 2'd1;
    localparam logic [1:0] ReqFill  = 2'd2;
    localparam logic [1:0] ReqRead  = 2'd3;

    localparam logic [1:0] StOk       = 2'd0;
    localparam logic [1:0] StBadCoord = 2'd1;
    localparam logic [1:0] StBadColor = 2'd2;

    localparam logic [1:0] CfgWidth   = 2'd0;
    localparam logic [1:0] CfgHeight  = 2'd1;
    localparam logic [1:0] CfgPalette = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] col_x;
        logic [7:0] row_y;
        logic [7:0] color_index;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  old_cell;
        logic [16:0] cells_changed;
    } t_rsp;

    // grid memory port request; the grid reads the addressed cell every cycle once its clearing sweep ends
    typedef struct packed {
        logic                          wr;
        logic [AddrBits-1:0]           addr;
        logic [ColorBits-1:0]          wdata;
    } t_mem_req;
endpackage

### rtl/core/gffp_if.sv
// Interface: valid/ready channel carrying one payload.
`timescale 1ns / 1ps
interface gffp_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/gffp_ram.sv
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module gffp_ram #(
    parameter int unsigned Depth = 256,
    parameter int unsigned Width = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### rtl/core/gffp_grid.sv
// Cell grid memory with an after-reset clearing sweep.
`timescale 1ns / 1ps
module gffp_grid (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  gffp_pkg::t_mem_req                     i_req,
    output logic [gffp_pkg::ColorBits-1:0]         o_rdata,
    output logic                                   o_ready
);
    logic [gffp_pkg::CntBits-1:0]  r_clr, n_clr;
    logic                          clearing;
    logic                          we;
    logic [gffp_pkg::AddrBits-1:0] addr;
    logic [gffp_pkg::ColorBits-1:0] wdata;

    assign clearing = !r_clr[gffp_pkg::CntBits-1];
    assign o_ready  = !clearing;
    assign n_clr    = clearing ? r_clr + 1'b1 : r_clr;
    assign we       = clearing | i_req.wr;
    assign addr     = clearing ? r_clr[gffp_pkg::AddrBits-1:0] : i_req.addr;
    assign wdata    = clearing ? '0 : i_req.wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else begin
            r_clr <= n_clr;
        end
    end

    gffp_ram #(.Depth(gffp_pkg::CellCount), .Width(gffp_pkg::ColorBits)) u_mem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(wdata),
        .o_rdata(o_rdata)
    );
endmodule

### rtl/core/gffp_ctrl.sv
// Request sequencer: single-cell requests and breadth-first flood fill.
`timescale 1ns / 1ps
module gffp_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [8:0]                     i_cfg_data,
    input  logic                           i_grid_ready,
    input  logic [gffp_pkg::ColorBits-1:0] i_grid_rdata,
    output gffp_pkg::t_mem_req             o_grid_req,
    gffp_if.sink                           req_if,
    gffp_if.source                         rsp_if
);
    localparam int unsigned AB = gffp_pkg::AddrBits;
    localparam int unsigned XB = gffp_pkg::XBits;
    localparam int unsigned YB = gffp_pkg::YBits;
    localparam int unsigned CB = gffp_pkg::ColorBits;
    localparam int unsigned QB = gffp_pkg::CntBits;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RD    = 8'b0000_0010,
        S_EXEC  = 8'b0000_0100,
        S_QPOP  = 8'b0000_1000,
        S_QWAIT = 8'b0001_0000,
        S_NRD   = 8'b0010_0000,
        S_NCHK  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [8:0] r_width, r_height;
    logic [7:0] r_pal;
    gffp_pkg::t_req r_req;
    logic [CB-1:0] r_old, r_color;
    logic [16:0] r_changed;
    logic [1:0]  r_status;
    logic [QB-1:0] r_head, r_tail;
    logic [AB-1:0] r_cur;
    logic [1:0]  r_dir;
    logic [AB-1:0] r_naddr;
    logic        r_rsp_v;

    // work queue memory
    logic [AB-1:0] r_queue [gffp_pkg::CellCount];
    logic [AB-1:0] r_qdata;
    logic          q_we;
    logic [AB-1:0] q_waddr;

    logic [8:0] eff_w, eff_h;
    logic [7:0] eff_pal;
    logic [XB-1:0] cx;
    logic [YB-1:0] cy;
    logic       nb_ok;
    logic [AB-1:0] nb_addr;
    logic [CB-1:0] new_color;

    assign eff_w   = (r_width > 9'(gffp_pkg::MaxWidth)) ? 9'(gffp_pkg::MaxWidth) : r_width;
    assign eff_h   = (r_height > 9'(gffp_pkg::MaxHeight)) ? 9'(gffp_pkg::MaxHeight) : r_height;
    assign eff_pal = (r_pal > 8'((1 << CB) - 1)) ? 8'((1 << CB) - 1) : r_pal;
    assign new_color = CB'(r_req.color_index + 8'd1);

    assign cx = r_cur[XB-1:0];
    assign cy = r_cur[AB-1:XB];

    // neighbor order: left, right, down (row+1), up (row-1)
    always_comb begin
        nb_ok   = 1'b0;
        nb_addr = r_cur;
        case (r_dir)
            2'd0: begin
                nb_ok   = cx != '0;
                nb_addr = {cy, cx - 1'b1};
            end
            2'd1: begin
                nb_ok   = 9'(cx) + 9'd1 < eff_w;
                nb_addr = {cy, cx + 1'b1};
            end
            2'd2: begin
                nb_ok   = 9'(cy) + 9'd1 < eff_h;
                nb_addr = {cy + 1'b1, cx};
            end
            default: begin
                nb_ok   = cy != '0;
                nb_addr = {cy - 1'b1, cx};
            end
        endcase
    end

    assign req_if.ready     = (r_state == S_IDLE) && i_grid_ready && !r_rsp_v;
    assign rsp_if.valid     = r_rsp_v;
    assign rsp_if.data      = '{status: r_status, old_cell: 8'(r_old), cells_changed: r_changed};

    logic rd_ok_coord, rd_bad_color;
    assign rd_ok_coord  = 9'(r_req.col_x) < eff_w && 9'(r_req.row_y) < eff_h;
    assign rd_bad_color = (r_req.req_type == gffp_pkg::ReqDraw ||
                           r_req.req_type == gffp_pkg::ReqFill) && r_req.color_index >= eff_pal;

    always_comb begin
        n_state = r_state;
        o_grid_req = '0;
        q_we = 1'b0;
        q_waddr = r_tail[AB-1:0];
        case (r_state)
            S_IDLE: if (req_if.valid && req_if.ready) n_state = S_RD;
            S_RD: begin
                if (rd_ok_coord) begin
                    o_grid_req.addr = {r_req.row_y[YB-1:0], r_req.col_x[XB-1:0]};
                    n_state = S_EXEC;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_EXEC: begin
                o_grid_req.addr = {r_req.row_y[YB-1:0], r_req.col_x[XB-1:0]};
                n_state = S_OUT;
                if (!rd_bad_color) begin
                    case (r_req.req_type)
                        gffp_pkg::ReqDraw: begin
                            o_grid_req.wr = 1'b1;
                            o_grid_req.wdata = new_color;
                        end
                        gffp_pkg::ReqErase: o_grid_req.wr = 1'b1;
                        gffp_pkg::ReqFill: if (i_grid_rdata != new_color) begin
                            o_grid_req.wr = 1'b1;
                            o_grid_req.wdata = new_color;
                            q_we = 1'b1;
                            n_state = S_QPOP;
                        end
                        default: ;
                    endcase
                end
            end
            S_QPOP: n_state = (r_head < r_tail) ? S_QWAIT : S_OUT;
            S_QWAIT: n_state = S_NRD;
            S_NRD: begin
                if (nb_ok) begin
                    o_grid_req.addr = nb_addr;
                    n_state = S_NCHK;
                end else begin
                    n_state = (r_dir == 2'd3) ? S_QPOP : S_NRD;
                end
            end
            S_NCHK: begin
                o_grid_req.addr = r_naddr;
                if (i_grid_rdata == r_old) begin
                    o_grid_req.wr = 1'b1;
                    o_grid_req.wdata = r_color;
                    q_we = 1'b1;
                end
                n_state = (r_dir == 2'd3) ? S_QPOP : S_NRD;
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (q_we) r_queue[q_waddr] <= o_grid_req.addr;
        r_qdata <= r_queue[r_head[AB-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= 9'd256;
            r_height <= 9'd256;
            r_pal    <= 8'd255;
            r_rsp_v  <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gffp_pkg::CfgWidth:   r_width  <= i_cfg_data;
                    gffp_pkg::CfgHeight:  r_height <= i_cfg_data;
                    gffp_pkg::CfgPalette: r_pal    <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (rsp_if.valid && rsp_if.ready) r_rsp_v <= 1'b0;
            if (r_state == S_OUT) r_rsp_v <= 1'b1;
            if (q_we) r_tail <= r_tail + 1'b1;
            if (r_state == S_RD) begin
                r_head <= '0;
                r_tail <= '0;
            end
            if (r_state == S_QPOP && r_head < r_tail) r_head <= r_head + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (req_if.valid && req_if.ready) r_req <= req_if.data;
            S_RD: begin
                r_old <= '0;
                r_changed <= '0;
                r_status <= rd_ok_coord ? gffp_pkg::StOk : gffp_pkg::StBadCoord;
            end
            S_EXEC: begin
                r_old <= i_grid_rdata;
                r_color <= new_color;
                if (rd_bad_color) r_status <= gffp_pkg::StBadColor;
                else if (o_grid_req.wr) r_changed <= 17'(o_grid_req.wdata != i_grid_rdata);
            end
            S_QWAIT: begin
                r_cur <= r_qdata;
                r_dir <= 2'd0;
            end
            S_NRD: begin
                r_naddr <= nb_addr;
                if (!nb_ok) r_dir <= r_dir + 1'b1;
            end
            S_NCHK: begin
                r_dir <= r_dir + 1'b1;
                if (i_grid_rdata == r_old) r_changed <= r_changed + 17'd1;
            end
            default: ;
        endcase
    end
endmodule

### rtl/core/grid_flood_fill_painter_core.sv
// Top level: grid flood-fill painter core.
// Usage:
//  - req_if carries a request (draw, erase, flood fill, read) with a cell
//    address and color index; rsp_if returns one response per request:
//    status, the cell's old value and the number of cells changed.
//  - Configuration (grid width, grid height, palette count) is written on
//    i_cfg_we/i_cfg_idx/i_cfg_data; the user must write it only while
//    the core is idle, which the core itself does not enforce.
//  - A single-cell request does a registered grid read, any write-back,
//    then the response; outside the grid it skips the grid access.
//  - A flood fill pops each queued cell, reads each in-grid neighbor and
//    recolors and queues each match. One request is in flight at a time;
//    the next is taken in the cycle after the response is handed off.
//  - After reset a clearing sweep writes every cell empty; no request is
//    taken until it ends. Configuration writes work throughout.
//  - A stalled receiver holds the response in its output register; the
//    core then takes no new request until it leaves.
`timescale 1ns / 1ps
module grid_flood_fill_painter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [8:0] i_cfg_data,
    gffp_if.sink       req_if,
    gffp_if.source     rsp_if
);
    gffp_pkg::t_mem_req                 grid_req;
    logic [gffp_pkg::ColorBits-1:0]     grid_rdata;
    logic                               grid_ready;

    gffp_grid u_grid (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (grid_req),
        .o_rdata(grid_rdata),
        .o_ready(grid_ready)
    );

    gffp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_grid_ready(grid_ready),
        .i_grid_rdata(grid_rdata),
        .o_grid_req  (grid_req),
        .req_if      (req_if),
        .rsp_if      (rsp_if)
    );
endmodule

### rtl/core/gffp_checker.sv
// Checker: port-level properties of the painter core, bound to the top level.
`timescale 1ns / 1ps
module gffp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [7:0]  rsp_old,
    input logic [16:0] rsp_changed
);
    a_no_accept_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !req_ready) else $error("request taken with response pending");
    a_rsp_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_changed))
        else $error("stalled response changed");
    a_bad_coord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_status == gffp_pkg::StBadCoord |-> rsp_old == '0 && rsp_changed == '0)
        else $error("out-of-grid response not empty");
    a_bad_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_status == gffp_pkg::StBadColor |-> rsp_changed == '0)
        else $error("palette error changed cells");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready |-> ##1 !rsp_valid ##1 !rsp_valid)
        else $error("response too early");
endmodule

bind grid_flood_fill_painter_core gffp_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .req_valid  (req_if.valid),
    .req_ready  (req_if.ready),
    .rsp_valid  (rsp_if.valid),
    .rsp_ready  (rsp_if.ready),
    .rsp_status (rsp_if.data.status),
    .rsp_old    (rsp_if.data.old_cell),
    .rsp_changed(rsp_if.data.cells_changed)
);

### tb/grid_flood_fill_painter_core_tb.sv
// Testbench for the grid flood-fill painter core: directed and random requests checked against a grid model.
`timescale 1ns / 1ps
module grid_flood_fill_painter_core_tb;
    import gffp_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = CfgWidth;
    logic [8:0] i_cfg_data = '0;

    gffp_if #(.T(t_req)) req_if ();
    gffp_if #(.T(t_rsp)) rsp_if ();

    grid_flood_fill_painter_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .req_if     (req_if.sink),
        .rsp_if     (rsp_if.source)
    );

    always #4 i_clk = ~i_clk;

    // Shadow of the painter: grid contents and configuration.
    logic [7:0] shadow_grid [CellCount];
    int unsigned cfg_w = 256, cfg_h = 256, cfg_pal = 255;
    int unsigned fill_queue [$];

    t_req pending_reqs [$];
    t_rsp expected_rsps [$];
    int   fail_count = 0;
    int   accepted_reqs = 0;
    int   checked_rsps = 0;
    int   fill_cells = 0;

    // Recolor one cell and append it to the fill queue when it matches.
    function automatic int paint_cell(int x, int y, logic [7:0] tgt, logic [7:0] col);
        int idx;
        if (x < 0 || y < 0 || x >= cfg_w || y >= cfg_h) return 0;
        idx = y * MaxWidth + x;
        if (shadow_grid[idx] != tgt) return 0;
        shadow_grid[idx] = col;
        fill_queue.insert(fill_queue.size(), idx);
        return 1;
    endfunction

    // Breadth-first region recolor; returns cells changed.
    function automatic int flood_region(int x0, int y0, logic [7:0] tgt, logic [7:0] col);
        int n;
        int idx, x, y;
        fill_queue.delete();
        n = paint_cell(x0, y0, tgt, col);
        while (fill_queue.size() > 0) begin
            idx = fill_queue.pop_front();
            x = idx % MaxWidth;
            y = idx / MaxWidth;
            n += paint_cell(x - 1, y, tgt, col);
            n += paint_cell(x + 1, y, tgt, col);
            n += paint_cell(x, y + 1, tgt, col);
            n += paint_cell(x, y - 1, tgt, col);
        end
        return n;
    endfunction

    // Apply one request to the shadow grid and return the response it must produce.
    function automatic t_rsp paint_response(t_req r);
        t_rsp       rsp;
        int         idx;
        logic [7:0] col;
        rsp = '0;
        if (r.col_x >= cfg_w || r.row_y >= cfg_h) begin
            rsp.status = StBadCoord;
            return rsp;
        end
        idx = r.row_y * MaxWidth + r.col_x;
        col = r.color_index + 8'd1;
        rsp.old_cell = shadow_grid[idx];
        if ((r.req_type == ReqDraw || r.req_type == ReqFill) && r.color_index >= cfg_pal) begin
            rsp.status = StBadColor;
        end else if (r.req_type == ReqDraw) begin
            rsp.cells_changed = 17'(rsp.old_cell != col);
            shadow_grid[idx] = col;
        end else if (r.req_type == ReqErase) begin
            rsp.cells_changed = 17'(rsp.old_cell != 0);
            shadow_grid[idx] = '0;
        end else if (r.req_type == ReqFill && rsp.old_cell != col) begin
            rsp.cells_changed = 17'(flood_region(r.col_x, r.row_y, rsp.old_cell, col));
            fill_cells += rsp.cells_changed;
        end
        return rsp;
    endfunction

    // Driver: bursts of requests separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.data  <= '0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_rsps.insert(expected_rsps.size(), paint_response(req_if.data));
                accepted_reqs++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    req_if.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    req_if.valid <= 1'b1;
                    req_if.data  <= pending_reqs.pop_front();
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern: long ready stretches broken by short stalls.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            rsp_if.ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left   <= $urandom_range(1, 7);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Monitor: compare each handed-off response to the oldest expectation.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_rsps.size() == 0) begin
                $error("response with nothing expected: %p", rsp_if.data);
                fail_count++;
            end else begin
                want = expected_rsps.pop_front();
                checked_rsps++;
                if (rsp_if.data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_if.data.status);
                    fail_count++;
                end
                if (rsp_if.data.old_cell !== want.old_cell) begin
                    $error("old_cell: expected %0d, got %0d",
                           want.old_cell, rsp_if.data.old_cell);
                    fail_count++;
                end
                if (rsp_if.data.cells_changed !== want.cells_changed) begin
                    $error("cells_changed: expected %0d, got %0d",
                           want.cells_changed, rsp_if.data.cells_changed);
                    fail_count++;
                end
            end
        end
    end

    task automatic add_req(logic [1:0] op, int x, int y, int c);
        t_req r;
        r.req_type    = op;
        r.col_x       = 8'(x);
        r.row_y       = 8'(y);
        r.color_index = 8'(c);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // Random request biased into the active grid and palette.
    task automatic add_random_req();
        int op, x, y, c;
        op = $urandom_range(0, 9);
        x = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
                                         : $urandom_range(0, cfg_w - 1);
        y = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
                                         : $urandom_range(0, cfg_h - 1);
        c = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
                                         : $urandom_range(0, (cfg_pal < 4) ? cfg_pal - 1 : 3);
        if (op < 5)      add_req(ReqDraw, x, y, c);
        else if (op < 6) add_req(ReqErase, x, y, c);
        else if (op < 8) add_req(ReqFill, x, y, c);
        else             add_req(ReqRead, x, y, c);
    endtask

    task automatic cfg_write(logic [1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= 9'(val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CfgWidth:  cfg_w   = (val > MaxWidth) ? MaxWidth : val;
            CfgHeight: cfg_h   = (val > MaxHeight) ? MaxHeight : val;
            default:   cfg_pal = val;
        endcase
    endtask

    // Wait until every queued request is taken and answered, plus a short settle.
    task automatic drain();
        while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < CellCount; i++) shadow_grid[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes at full grid, every request kind, each corner case.
        add_req(ReqRead, 255, 255, 0);
        add_req(ReqDraw, 0, 0, 254);
        add_req(ReqDraw, 0, 0, 254);      // redundant draw
        add_req(ReqDraw, 255, 255, 255);  // color outside palette
        add_req(ReqFill, 3, 3, 255);      // fill color outside palette
        add_req(ReqErase, 0, 0, 255);
        add_req(ReqErase, 0, 0, 0);       // redundant erase
        add_req(ReqDraw, 5, 0, 1);
        add_req(ReqDraw, 5, 1, 1);
        add_req(ReqDraw, 5, 2, 1);
        add_req(ReqFill, 170, 85, 1);     // large region, walls at column 5 rows 0..2
        add_req(ReqFill, 170, 85, 1);     // same color: nothing changes
        add_req(ReqFill, 0, 0, 0);        // region bounded by the grid edge
        add_req(ReqRead, 85, 170, 0);
        drain();

        // Small grid with narrow palette; stale colors stay as they are.
        cfg_write(CfgWidth, 1);
        cfg_write(CfgHeight, 1);
        cfg_write(CfgPalette, 1);
        add_req(ReqRead, 0, 0, 0);
        add_req(ReqDraw, 1, 0, 0);        // outside grid
        add_req(ReqDraw, 0, 1, 0);
        add_req(ReqFill, 0, 0, 1);
        add_req(ReqFill, 0, 0, 0);
        drain();

        // Random phases at several grid and palette settings.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin cfg_write(CfgWidth, 16); cfg_write(CfgHeight, 12);
                         cfg_write(CfgPalette, 3); end
                1: begin cfg_write(CfgWidth, 511); cfg_write(CfgHeight, 2);
                         cfg_write(CfgPalette, 255); end
                2: begin cfg_write(CfgWidth, 3); cfg_write(CfgHeight, 256);
                         cfg_write(CfgPalette, 2); end
                3: begin cfg_write(CfgWidth, 8); cfg_write(CfgHeight, 8);
                         cfg_write(CfgPalette, 4); end
                4: begin cfg_write(CfgWidth, 1); cfg_write(CfgHeight, 300);
                         cfg_write(CfgPalette, 128); end
                5: begin cfg_write(CfgWidth, $urandom_range(1, 40));
                         cfg_write(CfgHeight, $urandom_range(1, 40));
                         cfg_write(CfgPalette, $urandom_range(1, 255)); end
                6: begin cfg_write(CfgWidth, 24); cfg_write(CfgHeight, 20);
                         cfg_write(CfgPalette, 1); end
                default: begin cfg_write(CfgWidth, 256); cfg_write(CfgHeight, 256);
                         cfg_write(CfgPalette, 3); end
            endcase
            for (int k = 0; k < ((ph == 7) ? 60 : 220); k++) add_random_req();
            drain();
        end
        repeat (40) @(posedge i_clk);

        $display("%0d requests, %0d responses checked, %0d cells recolored by fills",
                 accepted_reqs, checked_rsps, fill_cells);
        if (fail_count == 0 && expected_rsps.size() == 0) begin
            $display("grid_flood_fill_painter_core_tb: clean");
        end else begin
            $display("grid_flood_fill_painter_core_tb: errors");
        end
        $finish;
    end

    // Run limit: clearing sweep plus full-grid fills on every request, many times over.
    initial begin
        #2s;
        $display("grid_flood_fill_painter_core_tb: errors");
        $finish;
    end
endmodule

### grid_flood_fill_painter_core.f
rtl/core/gffp_pkg.sv
rtl/core/gffp_if.sv
rtl/core/gffp_ram.sv
rtl/core/gffp_grid.sv
rtl/core/gffp_ctrl.sv
rtl/core/grid_flood_fill_painter_core.sv
rtl/core/gffp_checker.sv
tb/grid_flood_fill_painter_core_tb.sv
